### src/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, codes and constants of the bitmap block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

  localparam int MAP_BLOCKS_DEF = 1024;
  localparam int CELL_BITS_MAX  = 32;

  localparam int BLK_W   = 10;
  localparam int STAT_W  = 2;

  localparam logic [BLK_W-1:0] DISK_BLOCKS_RST     = 10'd1023;
  localparam logic [BLK_W-1:0] RESERVED_BLOCKS_RST = 10'd8;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_type_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK           = 2'd0,
    ST_NO_FREE      = 2'd1,
    ST_BAD_BLOCK    = 2'd2,
    ST_ALREADY_FREE = 2'd3
  } status_t;

  typedef enum logic {
    CFG_DISK_BLOCKS     = 1'b0,
    CFG_RESERVED_BLOCKS = 1'b1
  } cfg_index_t;

  // data area bounds as seen by every cell
  typedef struct packed {
    logic [BLK_W-1:0] res;
    logic [BLK_W-1:0] lim;
  } bba_cfg_t;

  // request travelling down the chain
  typedef struct packed {
    logic             valid;
    req_type_t        req_type;
    logic [BLK_W-1:0] blk;
    logic             bad;
    logic             done;
    logic             dbl;
    logic [BLK_W-1:0] idx;
    logic [BLK_W-1:0] acc;
  } bba_token_t;

endpackage

`default_nettype wire

### src/bba_if.sv
// ----------------------------------------------------------------------------
// bba_if
// Valid/ready channels of the bitmap block allocator: request, response and
// configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

interface bba_req_if;
  import bba_pkg::*;
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [BLK_W-1:0] block_number;
  modport source (output valid, req_type, block_number, input ready);
  modport sink   (input valid, req_type, block_number, output ready);
endinterface

interface bba_rsp_if;
  import bba_pkg::*;
  logic              valid;
  logic              ready;
  logic [BLK_W-1:0]  granted_block;
  logic [STAT_W-1:0] status;
  logic [BLK_W-1:0]  free_count;
  modport source (output valid, granted_block, status, free_count, input ready);
  modport sink   (input valid, granted_block, status, free_count, output ready);
endinterface

interface bba_cfg_if;
  import bba_pkg::*;
  logic             valid;
  logic             ready;
  logic             index;
  logic [BLK_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### src/bba_cell.sv
// ----------------------------------------------------------------------------
// bba_cell
// One cell of the allocation chain: holds a word of the used map, serves the
// passing request against it and adds its free bits to the running count.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_cell
  import bba_pkg::*;
#(
  parameter int MAP_BLOCKS = MAP_BLOCKS_DEF,
  parameter int CELL_BITS  = CELL_BITS_MAX,
  parameter int BASE       = 0
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       adv,
  input  wire bba_cfg_t   cfg,
  input  wire bba_token_t tin,
  output bba_token_t      tout
);

  localparam int AW = ($clog2(MAP_BLOCKS) + 1 > BLK_W + 1) ? $clog2(MAP_BLOCKS) + 1
                                                           : BLK_W + 1;
  localparam int OW = $clog2(CELL_BITS);

  logic [CELL_BITS-1:0] word;
  logic [CELL_BITS-1:0] word_next;
  logic [CELL_BITS-1:0] win;
  logic [CELL_BITS-1:0] avail;
  logic [CELL_BITS-1:0] first;
  logic [OW-1:0]        enc;
  logic [OW-1:0]        off;
  logic [AW-1:0]        blk_x;
  logic                 in_cell;
  bba_token_t           tnext;

  // window of the data area that falls in this word
  for (genvar j = 0; j < CELL_BITS; j++) begin : g_win
    localparam logic [AW-1:0] POS = AW'(BASE + j);
    assign win[j] = (POS >= AW'(cfg.res)) && (POS < AW'(cfg.lim));
  end

  assign avail = ~word & win;
  assign first = avail & (~avail + CELL_BITS'(1));

  always_comb begin
    enc = '0;
    for (int j = 0; j < CELL_BITS; j++) begin
      if (first[j]) begin
        enc = enc | OW'(j);
      end
    end
  end

  assign blk_x   = AW'(tin.blk);
  assign in_cell = (blk_x >= AW'(BASE)) && (blk_x < AW'(BASE + CELL_BITS));
  assign off     = OW'(blk_x - AW'(BASE));

  always_comb begin
    word_next = word;
    tnext     = tin;
    if (tin.valid) begin
      unique case (tin.req_type)
        REQ_ALLOC: begin
          if (!tin.done && (avail != '0)) begin
            word_next  = word | first;
            tnext.done = 1'b1;
            tnext.idx  = BLK_W'(AW'(BASE) + AW'(enc));
          end
        end
        REQ_FREE: begin
          if (!tin.bad && in_cell) begin
            if (word[off]) begin
              word_next[off] = 1'b0;
              tnext.done     = 1'b1;
              tnext.idx      = tin.blk;
            end else begin
              tnext.dbl = 1'b1;
            end
          end
        end
        default: ;
      endcase
      tnext.acc = tin.acc + BLK_W'($countones(~word_next & win));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word       <= '0;
      tout.valid <= 1'b0;
    end else if (adv) begin
      word <= word_next;
      tout <= tnext;
    end
  end

endmodule

`default_nettype wire

### src/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit block allocator over a one-bit-per-block used map, built as a
// chain of cells that each own one word of the map.
// ----------------------------------------------------------------------------
// the request walks the chain and is registered in each cell on its way from
//   request beat to response beat
// throughput: one request per cycle while the response side takes beats
// reset: map cleared, disk_blocks 1023, reserved_blocks 8
`default_nettype none

module bitmap_block_allocator
  import bba_pkg::*;
#(
  parameter int MAP_BLOCKS = MAP_BLOCKS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  bba_req_if.sink    req,
  bba_rsp_if.source  rsp,
  bba_cfg_if.sink    cfg
);

  localparam int CELL_BITS = (MAP_BLOCKS < CELL_BITS_MAX) ? MAP_BLOCKS : CELL_BITS_MAX;
  localparam int N_CELLS   = (MAP_BLOCKS + CELL_BITS - 1) / CELL_BITS;
  localparam int MW        = $clog2(MAP_BLOCKS + 1) > BLK_W ? $clog2(MAP_BLOCKS + 1)
                                                            : BLK_W;

  logic [BLK_W-1:0] disk_blocks;
  logic [BLK_W-1:0] reserved_blocks;
  bba_cfg_t         bounds;
  logic             adv;
  bba_token_t       tok [N_CELLS+1];
  bba_token_t       last;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      disk_blocks     <= DISK_BLOCKS_RST;
      reserved_blocks <= RESERVED_BLOCKS_RST;
    end else if (cfg.valid) begin
      unique case (cfg_index_t'(cfg.index))
        CFG_DISK_BLOCKS:     disk_blocks     <= cfg.data;
        CFG_RESERVED_BLOCKS: reserved_blocks <= cfg.data;
        default: ;
      endcase
    end
  end

  // effective disk size is capped by the map
  always_comb begin
    bounds.res = reserved_blocks;
    if (MW'(disk_blocks) < MW'(MAP_BLOCKS)) begin
      bounds.lim = disk_blocks;
    end else begin
      bounds.lim = BLK_W'(MAP_BLOCKS);
    end
  end

  // whole chain moves together, held while the response beat waits
  assign last      = tok[N_CELLS];
  assign adv       = !last.valid || rsp.ready;
  assign req.ready = adv;

  // block number only matters for a free
  always_comb begin
    tok[0]          = '0;
    tok[0].valid    = req.valid;
    tok[0].req_type = req_type_t'(req.req_type);
    tok[0].blk      = req.block_number;
    tok[0].bad      = (req.req_type == REQ_FREE) &&
                      ((req.block_number < bounds.res) || (req.block_number >= bounds.lim));
  end

  for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
    bba_cell #(
      .MAP_BLOCKS (MAP_BLOCKS),
      .CELL_BITS  (CELL_BITS),
      .BASE       (k * CELL_BITS)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .adv  (adv),
      .cfg  (bounds),
      .tin  (tok[k]),
      .tout (tok[k+1])
    );
  end

  // response from the end of the chain
  always_comb begin
    rsp.valid         = last.valid;
    rsp.granted_block = last.done ? last.idx : '0;
    rsp.free_count    = last.acc;
    unique case (last.req_type)
      REQ_ALLOC: rsp.status = last.done ? ST_OK : ST_NO_FREE;
      REQ_FREE: begin
        priority if (last.bad) begin
          rsp.status = ST_BAD_BLOCK;
        end else if (last.dbl) begin
          rsp.status = ST_ALREADY_FREE;
        end else begin
          rsp.status = ST_OK;
        end
      end
      default: rsp.status = ST_OK;
    endcase
  end

  // a granted allocation lies inside the data area
  a_alloc_in_area: assert property (@(posedge clk) disable iff (rst)
    (last.valid && last.req_type == REQ_ALLOC && last.done) |->
      (last.idx >= bounds.res && last.idx < bounds.lim))
    else $error("allocated block outside data area");

  // a request never both succeeds and fails
  a_outcome_exclusive: assert property (@(posedge clk) disable iff (rst)
    last.valid |-> !(last.done && (last.dbl || last.bad)))
    else $error("conflicting outcome flags");

  // free count never exceeds the data area size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    last.valid |-> ((bounds.res >= bounds.lim) ? (last.acc == '0)
                                               : (last.acc <= bounds.lim - bounds.res)))
    else $error("free count above data area size");

  // a stalled response holds its beat
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (last.valid && !rsp.ready) |=> ($stable(last) && last.valid))
    else $error("response changed while stalled");

endmodule

`default_nettype wire
